>>> rtl/r2e_pkg.sv
// Shared types, constants and helper functions for the rotation matrix to
// Euler angle converter. No dependencies.
package r2e_pkg;

	localparam int EW = 16;              // matrix element width
	localparam int AW = 16;              // output angle width
	localparam int CW = 57;              // CORDIC datapath width
	localparam int ZW = 32;              // internal binary angle width
	localparam int NW = 2 * EW + 1;      // roll numerator and denominator width
	localparam int GUARD = 29;
	localparam int NORM_TOP = 52;
	localparam int NB = NORM_TOP + 1;
	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
	localparam logic [ZW-1:0] HALF_TURN = 32'h80000000;

	localparam logic [ZW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [EW-1:0] r00;
		logic signed [EW-1:0] r10;
		logic signed [EW-1:0] r20;
		logic signed [EW-1:0] r01;
		logic signed [EW-1:0] r11;
		logic signed [EW-1:0] r02;
		logic signed [EW-1:0] r12;
	} request_t;

	typedef struct packed {
		logic signed [AW-1:0] yaw_angle;
		logic signed [AW-1:0] pitch_angle;
		logic signed [AW-1:0] roll_angle;
	} result_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [ZW-1:0] z;
		logic zf;             // zero vector, angle forced to zero
	} cordic_t;

	function automatic logic signed [CW-1:0] sx(input logic signed [EW-1:0] v);
		return CW'(v);
	endfunction

	// Turns a left half plane vector by pi and flags the zero vector.
	function automatic cordic_t pre_rotate(input logic signed [CW-1:0] x,
			input logic signed [CW-1:0] y);
		cordic_t c;
		c.zf = (x == '0) && (y == '0);
		if (x < 0) begin
			c.x = -x;
			c.y = -y;
			c.z = HALF_TURN;
		end else begin
			c.x = x;
			c.y = y;
			c.z = '0;
		end
		return c;
	endfunction

	function automatic logic [ZW-1:0] cordic_angle(input cordic_t c);
		return c.zf ? '0 : c.z;
	endfunction

	function automatic logic [AW-1:0] round_angle(input logic [ZW-1:0] z);
		logic [ZW-1:0] r;
		r = z + (ZW'(1) << (ZW - 1 - AW));
		return r[ZW-1 -: AW];
	endfunction

endpackage

>>> rtl/r2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its output register.
// Depends on r2e_pkg.
module r2e_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic             clk,
	input  r2e_pkg::cordic_t c_in,
	output r2e_pkg::cordic_t c_out
);
	import r2e_pkg::*;

	cordic_t c_q;
	logic signed [CW-1:0] dx, dy;

	assign dx = c_in.x >>> STAGE;
	assign dy = c_in.y >>> STAGE;

	always_ff @(posedge clk) begin
		c_q.zf <= c_in.zf;
		if (c_in.y >= 0) begin
			c_q.x <= c_in.x + dy;
			c_q.y <= c_in.y - dx;
			c_q.z <= c_in.z + ATAN_TAB[STAGE];
		end else begin
			c_q.x <= c_in.x - dy;
			c_q.y <= c_in.y + dx;
			c_q.z <= c_in.z - ATAN_TAB[STAGE];
		end
	end

	assign c_out = c_q;
endmodule

>>> rtl/r2e_mid.sv
// Between the yaw and the pitch/roll CORDIC rows: gain removal for pitch,
// roll cross products, leading-zero normalization and pre-rotation.
// Depends on r2e_pkg.
module r2e_mid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  r2e_pkg::cordic_t  yaw,
	input  r2e_pkg::request_t side,
	output logic              out_valid,
	output r2e_pkg::cordic_t  pitch_c,
	output r2e_pkg::cordic_t  roll_c,
	output logic [r2e_pkg::ZW-1:0] yaw_z
);
	import r2e_pkg::*;

	localparam int HOLD = 7;

	logic [9:0] v_q;
	logic [CW-1:0] m;

	logic [ZW-1:0] yz_s1, yz_s2, yz_f_q;
	logic [ZW-1:0] yz_q [HOLD];
	logic [CW-1:0] ph_s1;
	logic [63:0] pl_s1;
	logic signed [2*EW-1:0] pa_s1, pb_s1, pc_s1, pd_s1;
	logic zc_s1;
	logic signed [EW-1:0] r11_s1, r12_s1, r20_s1;

	logic signed [CW-1:0] hs_s2, py_s2;
	logic signed [NW-1:0] num_s2, den_s2;

	logic signed [CW-1:0] hs_q [HOLD];
	logic signed [CW-1:0] py_q [HOLD];
	logic signed [CW-1:0] num_q [HOLD];
	logic signed [CW-1:0] den_q [HOLD];
	logic [NB-1:0] big_q [HOLD];

	logic signed [CW-1:0] num_x, den_x;
	logic [NB-1:0] num_m, den_m;

	cordic_t pitch_q, roll_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[8:0], in_valid};
		end
	end

	assign m = yaw.x[CW-1] ? '0 : yaw.x;

	always_ff @(posedge clk) begin
		yz_s1  <= cordic_angle(yaw);
		ph_s1  <= CW'(m[CW-2:32]) * CW'(INV_GAIN);
		pl_s1  <= m[31:0] * INV_GAIN;
		pa_s1  <= side.r02 * side.r10;
		pb_s1  <= side.r12 * side.r00;
		pc_s1  <= side.r11 * side.r00;
		pd_s1  <= side.r01 * side.r10;
		zc_s1  <= (side.r00 == '0) && (side.r10 == '0);
		r11_s1 <= side.r11;
		r12_s1 <= side.r12;
		r20_s1 <= side.r20;
	end

	// A zero first column leaves roll as atan2(-r12, r11).
	always_ff @(posedge clk) begin
		yz_s2 <= yz_s1;
		hs_s2 <= CW'(ph_s1) + CW'(pl_s1[63:32]);
		py_s2 <= -(sx(r20_s1) <<< GUARD);
		if (zc_s1) begin
			num_s2 <= -NW'(r12_s1);
			den_s2 <= NW'(r11_s1);
		end else begin
			num_s2 <= NW'(pa_s1) - NW'(pb_s1);
			den_s2 <= NW'(pc_s1) - NW'(pd_s1);
		end
	end

	assign num_x = CW'(num_s2);
	assign den_x = CW'(den_s2);
	assign num_m = num_x < 0 ? NB'(-num_x) : NB'(num_x);
	assign den_m = den_x < 0 ? NB'(-den_x) : NB'(den_x);

	always_ff @(posedge clk) begin
		yz_q[0]  <= yz_s2;
		hs_q[0]  <= hs_s2;
		py_q[0]  <= py_s2;
		num_q[0] <= num_x;
		den_q[0] <= den_x;
		big_q[0] <= (num_m > den_m) ? num_m : den_m;
	end

	// Binary search shift: each stage shifts if the top SH bits are clear.
	for (genvar j = 0; j < HOLD - 1; j++) begin : g_norm
		localparam int SH = 32 >> j;
		always_ff @(posedge clk) begin
			yz_q[j+1] <= yz_q[j];
			hs_q[j+1] <= hs_q[j];
			py_q[j+1] <= py_q[j];
			if (big_q[j][NB-1 -: SH] == '0) begin
				num_q[j+1] <= num_q[j] <<< SH;
				den_q[j+1] <= den_q[j] <<< SH;
				big_q[j+1] <= big_q[j] << SH;
			end else begin
				num_q[j+1] <= num_q[j];
				den_q[j+1] <= den_q[j];
				big_q[j+1] <= big_q[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		yz_f_q  <= yz_q[HOLD-1];
		pitch_q <= pre_rotate(hs_q[HOLD-1], py_q[HOLD-1]);
		roll_q  <= pre_rotate(den_q[HOLD-1], num_q[HOLD-1]);
	end

	assign out_valid = v_q[9];
	assign pitch_c = pitch_q;
	assign roll_c = roll_q;
	assign yaw_z = yz_f_q;
endmodule

>>> rtl/rotation_matrix_to_euler.sv
// Rotation matrix to ZYX Euler angles: a row of CORDIC cells for yaw, then
// two rows in parallel for pitch and roll. Accepts one request per cycle;
// busy is always low. The delay from accept to done is set by the length of
// the two cell rows and the normalize stages. The receiver cannot stall.
// Reset clears only the valid bits of the rows and of the mid block.
module rotation_matrix_to_euler #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  r2e_pkg::request_t request,
	output logic              done,
	output r2e_pkg::result_t  result
);
	import r2e_pkg::*;

	localparam int N = CORDIC_STAGES;

	cordic_t yaw_front_s0;
	cordic_t yaw_c [N+1];
	request_t side_q [N+1];
	logic [N:0] yaw_v_q;

	logic mid_valid;
	cordic_t pitch_c [N+1];
	cordic_t roll_c [N+1];
	logic [ZW-1:0] yz_q [N+1];
	logic [N:0] pr_v_q;

	result_t result_q;

	assign busy = 1'b0;

	always_ff @(posedge clk) begin
		yaw_front_s0 <= pre_rotate(sx(request.r00) <<< GUARD, sx(request.r10) <<< GUARD);
		side_q[0] <= request;
	end

	assign yaw_c[0] = yaw_front_s0;

	// The mid block output is already registered, so pr_v_q[i] lines up with
	// pitch_c[i+1] and the last bit lines up with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_v_q <= '0;
			pr_v_q  <= '0;
		end else begin
			yaw_v_q <= {yaw_v_q[N-1:0], start & ~busy};
			pr_v_q  <= {pr_v_q[N-1:0], mid_valid};
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_yaw
		r2e_cordic_cell #(.STAGE(i)) u_cell (
			.clk  (clk),
			.c_in (yaw_c[i]),
			.c_out(yaw_c[i+1])
		);
		always_ff @(posedge clk) begin
			side_q[i+1] <= side_q[i];
		end
	end

	r2e_mid u_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (yaw_v_q[N]),
		.yaw      (yaw_c[N]),
		.side     (side_q[N]),
		.out_valid(mid_valid),
		.pitch_c  (pitch_c[0]),
		.roll_c   (roll_c[0]),
		.yaw_z    (yz_q[0])
	);

	for (genvar i = 0; i < N; i++) begin : g_pr
		r2e_cordic_cell #(.STAGE(i)) u_pitch (
			.clk  (clk),
			.c_in (pitch_c[i]),
			.c_out(pitch_c[i+1])
		);
		r2e_cordic_cell #(.STAGE(i)) u_roll (
			.clk  (clk),
			.c_in (roll_c[i]),
			.c_out(roll_c[i+1])
		);
		always_ff @(posedge clk) begin
			yz_q[i+1] <= yz_q[i];
		end
	end

	always_ff @(posedge clk) begin
		result_q.yaw_angle   <= round_angle(yz_q[N]);
		result_q.pitch_angle <= round_angle(cordic_angle(pitch_c[N]));
		result_q.roll_angle  <= round_angle(cordic_angle(roll_c[N]));
	end

	assign done = pr_v_q[N];
	assign result = result_q;
endmodule

>>> dv/rotation_matrix_to_euler_tb.sv
// Testbench for the rotation matrix to Euler angle converter: directed corner
// matrices, random rotations and random raw elements, checked against a CORDIC
// predictor. Depends on rtl/r2e_pkg.sv and rtl/rotation_matrix_to_euler.sv.
`timescale 1ns / 100ps

module rotation_matrix_to_euler_tb;
	import r2e_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 2 * STAGES + 12;
	localparam longint CYCLE_LIMIT = 400000;
	localparam real PI = 3.14159265358979;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;

	result_t pending_angles[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	longint cycles = 0;

	rotation_matrix_to_euler #(.CORDIC_STAGES(STAGES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Vectoring CORDIC on a 64-bit datapath, 32-bit binary angle.
	function automatic logic [31:0] vector_angle(input longint x, input longint y,
			output longint unsigned mag);
		logic [31:0] z;
		longint dx;
		longint dy;
		z = '0;
		mag = 0;
		if (x == 0 && y == 0) return '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN;
		end
		for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x = x + dy;
				y = y - dx;
				z = z + ATAN_TAB[i];
			end else begin
				x = x - dy;
				y = y + dx;
				z = z - ATAN_TAB[i];
			end
		end
		mag = (x < 0) ? 0 : longint'(x);
		return z;
	endfunction

	function automatic logic [AW-1:0] to_output_angle(input logic [31:0] z);
		logic [31:0] r;
		r = z + (32'd1 << (31 - AW));
		return r[31 -: AW];
	endfunction

	function automatic result_t euler_angles(input request_t q);
		longint r00, r10, r20, r01, r11, r02, r12;
		longint num, den;
		longint unsigned m, hs, unused, big, an, ad;
		logic [31:0] yaw, pitch, roll;
		int k;
		result_t res;
		r00 = q.r00; r10 = q.r10; r20 = q.r20; r01 = q.r01;
		r11 = q.r11; r02 = q.r02; r12 = q.r12;
		k = 0;
		yaw = vector_angle(r00 <<< GUARD, r10 <<< GUARD, m);
		// Strip the CORDIC gain from the yaw magnitude to get h scaled up.
		hs = (m >> 32) * longint'(INV_GAIN)
			+ (((m & 64'hFFFF_FFFF) * longint'(INV_GAIN)) >> 32);
		pitch = vector_angle(longint'(hs), (-r20) <<< GUARD, unused);
		if (r00 == 0 && r10 == 0) begin
			num = -r12;
			den = r11;
		end else begin
			num = r02 * r10 - r12 * r00;
			den = r11 * r00 - r01 * r10;
		end
		an = (num < 0) ? -num : num;
		ad = (den < 0) ? -den : den;
		big = (an > ad) ? an : ad;
		while (big != 0 && big < (64'd1 << NORM_TOP)) begin
			big = big << 1;
			k++;
		end
		roll = vector_angle(den <<< k, num <<< k, unused);
		res.yaw_angle = to_output_angle(yaw);
		res.pitch_angle = to_output_angle(pitch);
		res.roll_angle = to_output_angle(roll);
		return res;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: result with no request outstanding: %h", $time, result);
				errors++;
			end else begin
				want = pending_angles.pop_front();
				checked++;
				if (result.yaw_angle !== want.yaw_angle) begin
					$display("%0t: yaw expected %h actual %h", $time,
						want.yaw_angle, result.yaw_angle);
					errors++;
				end
				if (result.pitch_angle !== want.pitch_angle) begin
					$display("%0t: pitch expected %h actual %h", $time,
						want.pitch_angle, result.pitch_angle);
					errors++;
				end
				if (result.roll_angle !== want.roll_angle) begin
					$display("%0t: roll expected %h actual %h", $time,
						want.roll_angle, result.roll_angle);
					errors++;
				end
			end
		end
	end

	// Drives one request from a falling edge and holds it until accepted.
	task automatic send_matrix(input request_t q);
		@(negedge clk);
		start <= 1'b1;
		request <= q;
		#1;
		while (busy) @(negedge clk);
		pending_angles.push_back(euler_angles(q));
		sent++;
	endtask

	task automatic idle_cycles(input int n);
		for (int i = 0; i < n; i++) begin
			@(negedge clk);
			start <= 1'b0;
			request <= request_t'({$urandom, $urandom, $urandom, $urandom});
		end
	endtask

	task automatic wait_drained();
		idle_cycles(1);
		while (pending_angles.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [EW-1:0] to_q14(input real v);
		real s;
		s = v * 16384.0;
		if (s > 32767.0) s = 32767.0;
		if (s < -32768.0) s = -32768.0;
		return EW'($rtoi(s < 0 ? s - 0.5 : s + 0.5));
	endfunction

	function automatic request_t rotation(input real yw, input real pt, input real rl);
		request_t q;
		q.r00 = to_q14($cos(yw) * $cos(pt));
		q.r10 = to_q14($sin(yw) * $cos(pt));
		q.r20 = to_q14(-$sin(pt));
		q.r01 = to_q14($cos(yw) * $sin(pt) * $sin(rl) - $sin(yw) * $cos(rl));
		q.r11 = to_q14($sin(yw) * $sin(pt) * $sin(rl) + $cos(yw) * $cos(rl));
		q.r02 = to_q14($cos(yw) * $sin(pt) * $cos(rl) + $sin(yw) * $sin(rl));
		q.r12 = to_q14($sin(yw) * $sin(pt) * $cos(rl) - $cos(yw) * $sin(rl));
		return q;
	endfunction

	function automatic real rand_angle();
		return (real'($urandom_range(0, 65535)) / 32768.0 - 1.0) * PI;
	endfunction

	function automatic request_t random_raw();
		return request_t'({$urandom, $urandom, $urandom, $urandom});
	endfunction

	// Random bursts with random gaps; sometimes no gaps at all.
	task automatic pace();
		if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 6));
	endtask

	task automatic test_corners();
		request_t q;
		send_matrix('0);
		send_matrix({7{16'sh7FFF}});
		send_matrix({7{16'sh8000}});
		send_matrix(rotation(0.0, 0.0, 0.0));
		// Yaw of pi lands on the wrap point.
		send_matrix(rotation(PI, 0.0, 0.0));
		send_matrix(rotation(-PI / 2.0, 0.0, PI / 2.0));
		send_matrix(rotation(2.5, -1.0, -2.8));
		// Gimbal lock: zero first column, pitch is plus or minus a quarter turn.
		send_matrix(rotation(0.3, PI / 2.0, 0.7));
		send_matrix(rotation(0.3, -PI / 2.0, -0.7));
		q = '0;
		q.r20 = 16'sh8000;
		q.r11 = 16'sh8000;
		q.r12 = 16'sh7FFF;
		send_matrix(q);
		q = '0;
		q.r00 = -16'sd16384;
		q.r10 = -16'sd1;
		send_matrix(q);
		q = '0;
		q.r00 = 16'sh8000;
		q.r10 = 16'sh8000;
		q.r20 = 16'sh7FFF;
		send_matrix(q);
		q = {7{16'sh7FFF}};
		q.r00 = 16'sh8000;
		send_matrix(q);
		q = '0;
		q.r10 = 16'sd1;
		q.r02 = 16'sd1;
		send_matrix(q);
		idle_cycles(3);
	endtask

	task automatic test_random_rotations(input int n);
		for (int i = 0; i < n; i++) begin
			send_matrix(rotation(rand_angle(), rand_angle(), rand_angle()));
			pace();
		end
	endtask

	task automatic test_random_raw(input int n);
		request_t q;
		for (int i = 0; i < n; i++) begin
			q = random_raw();
			// Some raw items get a zero first column.
			if ($urandom_range(0, 5) == 0) begin
				q.r00 = '0;
				q.r10 = '0;
			end
			send_matrix(q);
			pace();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_corners();
		test_random_rotations(300);
		wait_drained();
		test_random_raw(200);
		test_random_rotations(300);
		test_random_raw(150);
		idle_cycles(1);
		while (pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d matrices (corners, random rotations, raw patterns), checked %0d.",
			sent, checked);
		if (errors == 0 && pending_angles.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
